// ===== rtl/reversible_ring_queue_defines.svh =====
// ----------------------------------------------------------------------------
// reversible_ring_queue_defines
// Assertion macros shared by the reversible ring queue RTL.
// ----------------------------------------------------------------------------
`ifndef REVERSIBLE_RING_QUEUE_DEFINES_SVH
`define REVERSIBLE_RING_QUEUE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define RRQ_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same on the block's own clock and reset
`define RRQ_ASSERT(lbl, prop, msg) \
  `RRQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/rrq_pkg.sv =====
// ----------------------------------------------------------------------------
// rrq_pkg
// Widths, codes and pointer helpers of the reversible ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rrq_pkg;

  localparam int RING_DEPTH = 128;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam int DATA_W = 32;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  localparam int IN_TDATA_W  = DATA_W;
  localparam int OUT_TDATA_W = ((DATA_W + OCC_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 1 + STAT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_REV = 2'd2,
    MODE_NOP = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(RING_DEPTH - 1) : idx - 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rrq_ram.sv =====
// ----------------------------------------------------------------------------
// rrq_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/reversible_ring_queue.sv =====
// Enqueue, reverse and no-op: result registered in the cycle after the request is taken.
// Dequeue: the word passes through the RAM read register, then is registered out from ST_READ.
// Throughput: one request per cycle unless the output stalls; none is taken during ST_READ.
// Reverse is a direction flag over the same ring, so it costs the same at any occupancy.
// Reset clears head, tail, count and direction; the ring RAM is not cleared.
// ----------------------------------------------------------------------------
// reversible_ring_queue
// Circular FIFO of 32-bit words held in one RAM, with an in-order reverse.
// ----------------------------------------------------------------------------
`default_nettype none
`include "reversible_ring_queue_defines.svh"

module reversible_ring_queue (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [rrq_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,  // [31:0] value
  input  wire logic [rrq_pkg::MODE_W-1:0]       s_axis_tuser_i,  // [1:0] mode
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  output logic      [rrq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,  // [31:0] data, [38:32] occupancy
  output logic      [rrq_pkg::OUT_TUSER_W-1:0]  m_axis_tuser_o   // [0] data_valid, [2:1] status
);
  import rrq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e            state_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] data_q;
  logic              data_valid_q;
  status_e           status_q;
  logic [OCC_W-1:0]  occ_q;

  logic [IDX_W-1:0]  head_q, tail_q, count_q;
  logic              rev_q;

  logic              req_accept, out_take, is_full, is_empty;
  mode_e             mode;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign mode       = mode_e'(s_axis_tuser_i);
  assign out_take   = out_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign req_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign is_full    = (count_q == IDX_W'(RING_DEPTH - 1));
  assign is_empty   = (count_q == '0);

  // Reversed: enqueue goes in front of the head, dequeue comes off the tail end
  assign ram_we    = req_accept && (mode == MODE_ENQ) && !is_full;
  assign ram_waddr = rev_q ? idx_dec(head_q) : tail_q;
  assign ram_re    = req_accept && (mode == MODE_DEQ) && !is_empty;
  assign ram_raddr = rev_q ? idx_dec(tail_q) : head_q;

  rrq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      data_q       <= '0;
      data_valid_q <= 1'b0;
      status_q     <= STAT_DONE;
      occ_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      rev_q        <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_accept) begin
            data_q       <= '0;
            data_valid_q <= 1'b0;
            status_q     <= STAT_DONE;
            occ_q        <= OCC_W'(count_q);
            out_valid_q  <= 1'b1;
            case (mode)
              MODE_ENQ: begin
                if (is_full) begin
                  status_q <= STAT_FULL;
                end else begin
                  if (rev_q) begin
                    head_q <= idx_dec(head_q);
                  end else begin
                    tail_q <= idx_inc(tail_q);
                  end
                  count_q <= count_q + 1'b1;
                  occ_q   <= OCC_W'(count_q + 1'b1);
                end
              end
              MODE_DEQ: begin
                if (is_empty) begin
                  status_q <= STAT_EMPTY;
                end else begin
                  // word comes back from the RAM next cycle
                  if (rev_q) begin
                    tail_q <= idx_dec(tail_q);
                  end else begin
                    head_q <= idx_inc(head_q);
                  end
                  count_q     <= count_q - 1'b1;
                  out_valid_q <= 1'b0;
                  state_q     <= ST_READ;
                end
              end
              MODE_REV: begin
                rev_q <= !rev_q;
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          data_q       <= ram_rdata;
          data_valid_q <= 1'b1;
          status_q     <= STAT_DONE;
          occ_q        <= OCC_W'(count_q);
          out_valid_q  <= 1'b1;
          state_q      <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({occ_q, data_q});
  assign m_axis_tuser_o  = {status_q, data_valid_q};

  `RRQ_ASSERT(a_deq_goes_read, req_accept && (mode == MODE_DEQ) && !is_empty |=> state_q == ST_READ, "dequeue did not start a RAM read")
  `RRQ_ASSERT(a_read_gives_result, state_q == ST_READ |=> out_valid_q && data_valid_q, "RAM read gave no result")
  `RRQ_ASSERT(a_full_drop_holds, req_accept && (mode == MODE_ENQ) && is_full |=> $stable(count_q) && $stable(tail_q) && $stable(head_q), "enqueue on a full ring changed the pointers")
  `RRQ_ASSERT(a_word_only_done, out_valid_q && data_valid_q |-> status_q == STAT_DONE, "dequeued word carries a fault status")

endmodule

`default_nettype wire
